@@ rtl/kdlp_pkg.sv @@
// ============================================================================
// kdlp_pkg: shared types and constants of the key debounce event queue
// Beat formats of both channels, event coding, register indexes and the
// default parameter values.
// ============================================================================
package kdlp_pkg;

    localparam int DEF_QUEUE_DEPTH = 256;
    localparam int DEF_KEY_COUNT   = 4;
    localparam int DEF_COUNT_WIDTH = 16;

    // Key indexes travel at the width of the largest supported key count.
    localparam int KEY_W_MAX = 4;
    // Only the low keys have a level bit; the others always read as released.
    localparam int LEVEL_W   = 4;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_TIME = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_TIME   = 1'b1;

    localparam logic [CFG_DATA_W-1:0] FILTER_TIME_RST = 16'd5;
    localparam logic [CFG_DATA_W-1:0] LONG_TIME_RST   = 16'd100;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam int QCOUNT_W = 9;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DOWN = 2'd1,
        KIND_UP   = 2'd2,
        KIND_LONG = 2'd3
    } kdlp_kind_t;

    typedef struct packed {
        logic                command;
        logic [LEVEL_W-1:0]  key_levels;
    } kdlp_in_t;

    typedef struct packed {
        logic                event_valid;
        logic [1:0]          key_index;
        kdlp_kind_t          event_kind;
        logic [QCOUNT_W-1:0] queue_count;
        logic                overflow;
    } kdlp_out_t;

    typedef struct packed {
        logic [1:0] key;
        kdlp_kind_t kind;
    } kdlp_event_t;

    typedef struct packed {
        logic        valid;
        kdlp_event_t evt;
    } kdlp_push_t;

    typedef struct packed {
        logic                 valid;
        logic [KEY_W_MAX-1:0] key;
        logic                 down;
    } kdlp_key_op_t;

endpackage

@@ rtl/kdlp_key_engine.sv @@
// ============================================================================
// kdlp_key_engine: per-key debounce state
// Holds filter counter, long-press counter and pressed flag of every key in
// a small memory; reads a key at issue and writes the updated state back from
// the second stage, forwarding the last write when the same key follows itself.
// ============================================================================
module kdlp_key_engine #(
    parameter int KEY_COUNT   = kdlp_pkg::DEF_KEY_COUNT,
    parameter int COUNT_WIDTH = kdlp_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  kdlp_pkg::kdlp_key_op_t              iss_op,
    input  kdlp_pkg::kdlp_key_op_t              s2_op,
    input  logic [kdlp_pkg::CFG_DATA_W-1:0]     filter_time,
    input  logic [kdlp_pkg::CFG_DATA_W-1:0]     long_time,
    output kdlp_pkg::kdlp_push_t                push
);
    import kdlp_pkg::*;

    localparam int KIDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int FC_W   = COUNT_WIDTH;
    localparam int LC_W   = COUNT_WIDTH + 1;
    localparam int CMP_W  = (LC_W > CFG_DATA_W) ? LC_W : CFG_DATA_W;

    localparam logic [FC_W-1:0] FC_MAX = {FC_W{1'b1}};
    localparam logic [LC_W-1:0] LC_MAX = {LC_W{1'b1}};

    typedef struct packed {
        logic            pressed;
        logic [LC_W-1:0] lc;
        logic [FC_W-1:0] fc;
    } key_state_t;

    key_state_t key_mem [KEY_COUNT];
    key_state_t rdata_reg;
    key_state_t fwd_reg;
    logic [KIDX_W-1:0]    fwd_key_reg;
    logic                 fwd_vld_reg;
    logic                 rvld_reg;
    logic [KEY_COUNT-1:0] written_reg;

    logic [KIDX_W-1:0] iss_idx;
    logic [KIDX_W-1:0] s2_idx;
    key_state_t        cur;
    key_state_t        st_next;
    logic [CMP_W-1:0]  fc_x;
    logic [CMP_W-1:0]  lc_x;
    logic [CMP_W-1:0]  ft_x;
    logic [CMP_W-1:0]  lt_x;
    logic              do_rd;
    logic              do_wr;

    assign iss_idx = iss_op.key[KIDX_W-1:0];
    assign s2_idx  = s2_op.key[KIDX_W-1:0];
    assign do_rd   = advance && iss_op.valid;
    assign do_wr   = advance && s2_op.valid;

    always_ff @(posedge aclk) begin
        if (do_rd) begin
            rdata_reg <= key_mem[iss_idx];
        end
        if (do_wr) begin
            key_mem[s2_idx] <= st_next;
            fwd_reg         <= st_next;
            fwd_key_reg     <= s2_idx;
        end
    end

    // Entries never written read as the reset state, all counters at zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            rvld_reg    <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end else begin
            if (do_rd) begin
                rvld_reg <= written_reg[iss_idx];
            end
            if (do_wr) begin
                written_reg[s2_idx] <= 1'b1;
                fwd_vld_reg         <= 1'b1;
            end
        end
    end

    always_comb begin
        if (fwd_vld_reg && (fwd_key_reg == s2_idx)) begin
            cur = fwd_reg;
        end else if (rvld_reg) begin
            cur = rdata_reg;
        end else begin
            cur = '0;
        end

        fc_x = CMP_W'(cur.fc);
        lc_x = CMP_W'(cur.lc);
        ft_x = CMP_W'(filter_time);
        lt_x = CMP_W'(long_time);

        st_next       = cur;
        push.valid    = 1'b0;
        push.evt.key  = s2_op.key[1:0];
        push.evt.kind = KIND_NONE;

        if (s2_op.down) begin
            if ((fc_x < ft_x) && (cur.fc != FC_MAX)) begin
                st_next.fc = cur.fc + FC_W'(1);
            end else if (!cur.pressed) begin
                st_next.pressed = 1'b1;
                push.valid      = 1'b1;
                push.evt.kind   = KIND_DOWN;
            end else begin
                if (cur.lc != LC_MAX) begin
                    st_next.lc = cur.lc + LC_W'(1);
                end
                if (lc_x == lt_x) begin
                    push.valid    = 1'b1;
                    push.evt.kind = KIND_LONG;
                end
            end
        end else begin
            if (cur.fc != '0) begin
                st_next.fc = cur.fc - FC_W'(1);
            end else begin
                if (cur.pressed) begin
                    st_next.pressed = 1'b0;
                    push.valid      = 1'b1;
                    push.evt.kind   = KIND_UP;
                end
                st_next.lc = '0;
            end
        end
    end

endmodule

@@ rtl/kdlp_event_queue.sv @@
// ============================================================================
// kdlp_event_queue: event FIFO
// Circular buffer of four-bit events in a synchronous memory with read and
// write pointers and a fill count. Pushes that find it full are dropped.
// ============================================================================
module kdlp_event_queue #(
    parameter int QUEUE_DEPTH = kdlp_pkg::DEF_QUEUE_DEPTH,
    parameter int CNT_W       = $clog2(kdlp_pkg::DEF_QUEUE_DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pop_en,
    input  logic                   push_en,
    input  kdlp_pkg::kdlp_event_t  push_evt,
    output logic                   full,
    output logic [CNT_W-1:0]       count_after,
    output logic                   pop_hit,
    output kdlp_pkg::kdlp_event_t  pop_evt
);
    import kdlp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    kdlp_event_t evt_mem [QUEUE_DEPTH];
    kdlp_event_t rdata_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop_hit_reg;
    logic             push_ok;
    logic             pop_ok;

    assign full        = (count_reg == CNT_FULL);
    assign push_ok     = push_en && !full;
    assign pop_ok      = pop_en && (count_reg != '0);
    assign count_after = count_reg + CNT_W'(push_ok);
    assign pop_hit     = pop_hit_reg;
    assign pop_evt     = rdata_reg;

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            evt_mem[wr_ptr_reg] <= push_evt;
        end
        if (pop_en) begin
            rdata_reg <= evt_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            count_reg   <= '0;
            pop_hit_reg <= 1'b0;
        end else begin
            if (pop_en) begin
                pop_hit_reg <= pop_ok;
            end
            if (push_ok) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop_ok) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push_ok) - CNT_W'(pop_ok);
        end
    end

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("event count beyond queue depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty queue with pointers apart");

    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_en && (count_reg == '0)) |=> !pop_hit_reg)
        else $error("pop from empty queue returned an event");

endmodule

@@ rtl/key_debounce_long_press_queue_top.sv @@
// ============================================================================
// key_debounce_long_press_queue_top: debounced keys with long press and queue
// Scan ticks update the per-key debounce state and queue down, up and long
// events; pop beats return the oldest queued event.
// ============================================================================
// A scan beat holds the input busy while it issues every key of the scan in turn,
// because every key makes one read and one write-back of the key-state memory
// and may push one event through the single write port of the event memory.
// A pop is not accepted while a key update is still in the second stage, so
// that it sees the last key's event. Each result passes through the second
// stage registers into the output register. While a result waits there, no
// beat is accepted; the next beat can be accepted in the cycle that the result
// leaves. After reset the block is usable at once; the event memory needs no
// clearing pass, and a stall on the result channel holds the whole pipeline.
module key_debounce_long_press_queue_top #(
    parameter int QUEUE_DEPTH = kdlp_pkg::DEF_QUEUE_DEPTH,
    parameter int KEY_COUNT   = kdlp_pkg::DEF_KEY_COUNT,
    parameter int COUNT_WIDTH = kdlp_pkg::DEF_COUNT_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  kdlp_pkg::kdlp_in_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output kdlp_pkg::kdlp_out_t              m_data,
    input  logic                             cfg_we,
    input  logic [kdlp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [kdlp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import kdlp_pkg::*;

    localparam int KIDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam logic [KIDX_W-1:0] KEY_LAST = KIDX_W'(KEY_COUNT - 1);

    logic [CFG_DATA_W-1:0] filter_time_reg;
    logic [CFG_DATA_W-1:0] long_time_reg;

    logic                busy_reg;
    logic [KIDX_W-1:0]   key_cnt_reg;
    logic [LEVEL_W-1:0]  levels_reg;

    logic                 s2_vld_reg;
    logic                 s2_pop_reg;
    logic                 s2_first_reg;
    logic                 s2_last_reg;
    logic [KEY_W_MAX-1:0] s2_key_reg;
    logic                 s2_down_reg;
    logic                 ovf_acc_reg;

    logic      m_valid_reg;
    kdlp_out_t m_data_reg;

    logic                 advance;
    logic                 acc;
    logic                 iss_scan;
    logic                 iss_pop;
    logic [KIDX_W-1:0]    iss_kidx;
    logic [KEY_W_MAX-1:0] iss_key;
    logic [LEVEL_W-1:0]   iss_levels;
    logic                 iss_first;
    logic                 iss_last;
    logic                 iss_down;

    kdlp_key_op_t iss_op;
    kdlp_key_op_t s2_op;
    kdlp_push_t   push;

    logic             q_full;
    logic [CNT_W-1:0] q_count_after;
    logic             q_pop_hit;
    kdlp_event_t      q_pop_evt;
    logic             push_en;
    logic             drop;
    logic [CNT_W+QCOUNT_W-1:0] qc_ext;
    kdlp_out_t        result;
    logic             result_vld;

    // The whole pipeline moves only while the output register can take a beat.
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance && !busy_reg
                     && !((s_data.command == CMD_POP) && s2_op.valid);
    assign acc     = s_valid && s_ready;

    assign iss_pop    = acc && (s_data.command == CMD_POP);
    assign iss_scan   = advance && (busy_reg || (acc && (s_data.command == CMD_SCAN)));
    assign iss_kidx   = busy_reg ? key_cnt_reg : '0;
    assign iss_key    = KEY_W_MAX'(iss_kidx);
    assign iss_levels = busy_reg ? levels_reg : s_data.key_levels;
    assign iss_first  = !busy_reg;
    assign iss_last   = busy_reg ? (key_cnt_reg == KEY_LAST) : (KEY_COUNT == 1);
    assign iss_down   = (iss_key < KEY_W_MAX'(LEVEL_W)) && iss_levels[iss_key[1:0]];

    assign iss_op.valid = iss_scan;
    assign iss_op.key   = iss_key;
    assign iss_op.down  = iss_down;

    assign s2_op.valid = s2_vld_reg && !s2_pop_reg;
    assign s2_op.key   = s2_key_reg;
    assign s2_op.down  = s2_down_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_time_reg <= FILTER_TIME_RST;
            long_time_reg   <= LONG_TIME_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_FILTER_TIME: filter_time_reg <= cfg_wdata;
                CFG_LONG_TIME:   long_time_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            key_cnt_reg <= '0;
        end else if (advance) begin
            if (acc && (s_data.command == CMD_SCAN) && (KEY_COUNT > 1)) begin
                busy_reg    <= 1'b1;
                key_cnt_reg <= KIDX_W'(1);
            end else if (busy_reg) begin
                if (key_cnt_reg == KEY_LAST) begin
                    busy_reg <= 1'b0;
                end
                key_cnt_reg <= key_cnt_reg + KIDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            levels_reg <= s_data.key_levels;
        end
        if (advance) begin
            s2_key_reg   <= iss_key;
            s2_down_reg  <= iss_down;
            s2_first_reg <= iss_first;
            s2_last_reg  <= iss_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg  <= 1'b0;
            s2_pop_reg  <= 1'b0;
            ovf_acc_reg <= 1'b0;
        end else if (advance) begin
            s2_vld_reg <= iss_scan || iss_pop;
            s2_pop_reg <= iss_pop;
            if (s2_op.valid) begin
                ovf_acc_reg <= (s2_first_reg ? 1'b0 : ovf_acc_reg) | drop;
            end
        end
    end

    kdlp_key_engine #(
        .KEY_COUNT   (KEY_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_key_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .iss_op      (iss_op),
        .s2_op       (s2_op),
        .filter_time (filter_time_reg),
        .long_time   (long_time_reg),
        .push        (push)
    );

    assign push_en = advance && s2_op.valid && push.valid;
    assign drop    = s2_op.valid && push.valid && q_full;

    kdlp_event_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_event_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_en      (iss_pop),
        .push_en     (push_en),
        .push_evt    (push.evt),
        .full        (q_full),
        .count_after (q_count_after),
        .pop_hit     (q_pop_hit),
        .pop_evt     (q_pop_evt)
    );

    assign qc_ext     = {{QCOUNT_W{1'b0}}, q_count_after};
    assign result_vld = s2_vld_reg && (s2_pop_reg || s2_last_reg);

    always_comb begin
        result.queue_count = qc_ext[QCOUNT_W-1:0];
        if (s2_pop_reg) begin
            result.event_valid = q_pop_hit;
            result.key_index   = q_pop_hit ? q_pop_evt.key : 2'd0;
            result.event_kind  = q_pop_hit ? q_pop_evt.kind : KIND_NONE;
            result.overflow    = 1'b0;
        end else begin
            result.event_valid = 1'b0;
            result.key_index   = 2'd0;
            result.event_kind  = KIND_NONE;
            result.overflow    = (s2_first_reg ? 1'b0 : ovf_acc_reg) | drop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= result_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result_vld) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_ready)
        else $error("beat accepted during a multi-cycle scan");

    a_pop_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        iss_pop |-> !s2_op.valid)
        else $error("pop issued while a key update is in flight");

    a_event_has_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.event_valid) |-> (m_data_reg.event_kind != KIND_NONE))
        else $error("popped event without a kind");

    a_scan_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result_vld && !s2_pop_reg) |=> !m_data_reg.event_valid)
        else $error("scan result flagged as event");

endmodule
